/* rtl/stt_pkg.sv */
`timescale 1ns / 1ps

package stt_pkg;

  // Width of the slot field and of any cell index (the slot field addresses at most 16 slots).
  localparam int SLOT_W = 4;
  localparam int IDX_W  = 6;

  typedef enum logic [2:0] {
    CMD_REG     = 3'd0,
    CMD_START   = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_DEL     = 3'd3,
    CMD_DEL_ALL = 3'd4,
    CMD_SCAN    = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_FIRE   = 2'd1,
    KIND_DONE   = 2'd2
  } kind_t;

  localparam logic ST_OK        = 1'b0;
  localparam logic ST_NOT_FOUND = 1'b1;

  // Command broadcast from the top level to every cell.
  typedef struct packed {
    logic              go;
    cmd_t              op;
    logic [SLOT_W-1:0] slot;
    logic              single_run;
    logic              start_now;
    logic              notify_enable;
  } bus_t;

  // Scan token handed from one cell to the next.
  typedef struct packed {
    logic valid;
    logic dead;
  } tok_t;

  // What a cell reports in the cycle it holds the live token.
  typedef struct packed {
    logic fire;
    logic free;
  } ev_t;

endpackage

/* rtl/soft_timer_table.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Ports
// input     in         start high, busy low  in_cmd in_slot in_period in_single_run
//                                            in_start_now in_notify_enable in_now
// result    out        out_valid strobe      out_kind out_status out_slot_id out_freed out_last
//
// Register, start, stop, delete and delete-all give their status beat in the cycle
// after the command is taken; busy stays low, so commands can arrive back to back.
// A scan walks a token along the row of slot cells, one cell per cycle, and the scan-done
// beat follows the last cell. busy is high from the cycle after the scan is taken until
// the scan-done beat is shown.
// Reset is synchronous and clears all slot flags; periods and reload ticks are not reset.
// The receiver cannot stall: every result beat is shown for exactly one cycle.

module soft_timer_table #(
  parameter int NUM_SLOTS = 16,
  parameter int TICK_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [3:0]  in_slot,
  input  logic [31:0] in_period,
  input  logic        in_single_run,
  input  logic        in_start_now,
  input  logic        in_notify_enable,
  input  logic [31:0] in_now,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic        out_status,
  output logic [3:0]  out_slot_id,
  output logic        out_freed,
  output logic        out_last
);
  import stt_pkg::*;

  // The scan is in flight while scan_r is set; go_r injects the token into cell zero.
  logic                 scan_r, scan_nxt;
  logic                 go_r, go_nxt;
  logic [TICK_BITS-1:0] now_r, now_nxt;
  logic                 freed_r, freed_nxt;
  logic [SLOT_W-1:0]    fid_r, fid_nxt;

  logic                 out_valid_r, out_valid_nxt;
  kind_t                out_kind_r, out_kind_nxt;
  logic                 out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]    out_slot_id_r, out_slot_id_nxt;
  logic                 out_freed_r, out_freed_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 accept;
  cmd_t                 op;
  bus_t                 bus;
  logic [TICK_BITS-1:0] cmd_period;
  logic [TICK_BITS-1:0] cmd_now;

  tok_t                 tok [NUM_SLOTS+1];
  ev_t                  ev [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] hit;
  logic [NUM_SLOTS-1:0] fire_vec;
  logic [NUM_SLOTS-1:0] free_vec;
  logic [SLOT_W-1:0]    fire_id;
  logic [SLOT_W-1:0]    free_id;
  logic                 in_table;

  assign accept     = start && !busy;
  assign op         = cmd_t'(in_cmd);
  assign cmd_period = TICK_BITS'(in_period);
  assign cmd_now    = TICK_BITS'(in_now);
  assign in_table   = IDX_W'(in_slot) < IDX_W'(NUM_SLOTS);

  // Only the edit commands reach the cells; a scan travels as the token instead.
  always_comb begin
    bus.go            = accept && (op != CMD_SCAN);
    bus.op            = op;
    bus.slot          = in_slot;
    bus.single_run    = in_single_run;
    bus.start_now     = in_start_now;
    bus.notify_enable = in_notify_enable;
  end

  assign tok[0].valid = go_r;
  assign tok[0].dead  = 1'b0;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    stt_cell #(
      .TICK_BITS(TICK_BITS),
      .IDX      (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .bus_i     (bus),
      .period_i  (cmd_period),
      .now_i     (cmd_now),
      .scan_now_i(now_r),
      .tok_i     (tok[i]),
      .tok_o     (tok[i+1]),
      .ev_o      (ev[i]),
      .hit_o     (hit[i])
    );
    assign fire_vec[i] = ev[i].fire;
    assign free_vec[i] = ev[i].free;
  end

  // At most one cell holds the live token, so these vectors are one-hot or empty.
  always_comb begin
    fire_id = '0;
    free_id = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (fire_vec[i]) begin
        fire_id = fire_id | SLOT_W'(i);
      end
      if (free_vec[i]) begin
        free_id = free_id | SLOT_W'(i);
      end
    end
  end

  always_comb begin
    scan_nxt        = scan_r;
    go_nxt          = 1'b0;
    now_nxt         = now_r;
    freed_nxt       = freed_r;
    fid_nxt         = fid_r;
    out_valid_nxt   = 1'b0;
    out_kind_nxt    = out_kind_r;
    out_status_nxt  = out_status_r;
    out_slot_id_nxt = out_slot_id_r;
    out_freed_nxt   = out_freed_r;
    out_last_nxt    = out_last_r;

    if (accept) begin
      out_kind_nxt    = KIND_STATUS;
      out_freed_nxt   = 1'b0;
      out_last_nxt    = 1'b1;
      out_slot_id_nxt = in_slot;
      case (op)
        CMD_REG: begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = in_table ? ST_OK : ST_NOT_FOUND;
        end
        CMD_START, CMD_STOP, CMD_DEL: begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = (|hit) ? ST_OK : ST_NOT_FOUND;
        end
        CMD_DEL_ALL: begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_OK;
          out_slot_id_nxt = '0;
        end
        CMD_SCAN: begin
          scan_nxt  = 1'b1;
          go_nxt    = 1'b1;
          now_nxt   = cmd_now;
          freed_nxt = 1'b0;
          fid_nxt   = '0;
        end
        default: begin
        end
      endcase
    end

    if (scan_r) begin
      if (|free_vec) begin
        freed_nxt = 1'b1;
        fid_nxt   = free_id;
      end
      if (|fire_vec) begin
        out_valid_nxt   = 1'b1;
        out_kind_nxt    = KIND_FIRE;
        out_status_nxt  = ST_OK;
        out_slot_id_nxt = fire_id;
        out_freed_nxt   = 1'b0;
        out_last_nxt    = 1'b0;
      end else if (tok[NUM_SLOTS].valid) begin
        // The token has left the last cell; any free it saw is already in fid_r.
        out_valid_nxt   = 1'b1;
        out_kind_nxt    = KIND_DONE;
        out_status_nxt  = ST_OK;
        out_slot_id_nxt = fid_r;
        out_freed_nxt   = freed_r;
        out_last_nxt    = 1'b1;
        scan_nxt        = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r      <= 1'b0;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      freed_r     <= 1'b0;
      fid_r       <= '0;
    end else begin
      scan_r      <= scan_nxt;
      go_r        <= go_nxt;
      out_valid_r <= out_valid_nxt;
      freed_r     <= freed_nxt;
      fid_r       <= fid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r         <= now_nxt;
    out_kind_r    <= out_kind_nxt;
    out_status_r  <= out_status_nxt;
    out_slot_id_r <= out_slot_id_nxt;
    out_freed_r   <= out_freed_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign busy        = scan_r;
  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_status  = out_status_r;
  assign out_slot_id = out_slot_id_r;
  assign out_freed   = out_freed_r;
  assign out_last    = out_last_r;

endmodule

/* rtl/stt_cell.sv */
`timescale 1ns / 1ps

module stt_cell #(
  parameter int TICK_BITS = 32,
  parameter int IDX       = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  stt_pkg::bus_t        bus_i,
  input  logic [TICK_BITS-1:0] period_i,
  input  logic [TICK_BITS-1:0] now_i,
  input  logic [TICK_BITS-1:0] scan_now_i,
  input  stt_pkg::tok_t        tok_i,
  output stt_pkg::tok_t        tok_o,
  output stt_pkg::ev_t         ev_o,
  output logic                 hit_o
);
  import stt_pkg::*;

  logic                 used_r, used_nxt;
  logic                 active_r, active_nxt;
  logic                 single_r, single_nxt;
  logic                 killed_r, killed_nxt;
  logic                 notify_r, notify_nxt;
  logic [TICK_BITS-1:0] period_r, period_nxt;
  logic [TICK_BITS-1:0] reload_r, reload_nxt;
  tok_t                 tok_r, tok_nxt;

  logic                 sel;
  logic                 live;
  logic                 due;
  logic                 act_after;
  logic                 fire;
  logic                 free;
  logic [TICK_BITS-1:0] elapsed;

  assign sel       = bus_i.go && (IDX_W'(bus_i.slot) == IDX_W'(IDX));
  assign live      = tok_i.valid && !tok_i.dead;
  assign elapsed   = scan_now_i - reload_r;
  assign due       = live && used_r && active_r && (elapsed >= period_r);
  assign act_after = due ? (active_r && !single_r) : active_r;
  assign fire      = due && notify_r && !killed_r;
  assign free      = live && used_r && !act_after && (single_r || killed_r);

  assign hit_o      = sel && used_r;
  assign ev_o.fire  = fire;
  assign ev_o.free  = free;
  assign tok_o      = tok_r;

  always_comb begin
    used_nxt      = used_r;
    active_nxt    = active_r;
    single_nxt    = single_r;
    killed_nxt    = killed_r;
    notify_nxt    = notify_r;
    period_nxt    = period_r;
    reload_nxt    = reload_r;
    tok_nxt.valid = tok_i.valid;
    tok_nxt.dead  = tok_i.dead || free;
    if (live) begin
      active_nxt = act_after;
      if (due) begin
        reload_nxt = scan_now_i;
      end
      if (free) begin
        used_nxt   = 1'b0;
        single_nxt = 1'b0;
        killed_nxt = 1'b0;
        notify_nxt = 1'b0;
      end
    end else if (bus_i.go) begin
      case (bus_i.op)
        CMD_REG: begin
          if (sel) begin
            used_nxt   = 1'b1;
            active_nxt = bus_i.start_now;
            single_nxt = bus_i.single_run;
            killed_nxt = 1'b0;
            notify_nxt = bus_i.notify_enable;
            period_nxt = period_i;
            reload_nxt = now_i;
          end
        end
        CMD_START: begin
          if (sel && used_r) begin
            active_nxt = 1'b1;
          end
        end
        CMD_STOP: begin
          if (sel && used_r) begin
            active_nxt = 1'b0;
          end
        end
        CMD_DEL: begin
          if (sel && used_r) begin
            active_nxt = 1'b0;
            killed_nxt = 1'b1;
          end
        end
        CMD_DEL_ALL: begin
          if (used_r) begin
            active_nxt = 1'b0;
            killed_nxt = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= 1'b0;
      active_r <= 1'b0;
      single_r <= 1'b0;
      killed_r <= 1'b0;
      notify_r <= 1'b0;
      tok_r    <= '0;
    end else begin
      used_r   <= used_nxt;
      active_r <= active_nxt;
      single_r <= single_nxt;
      killed_r <= killed_nxt;
      notify_r <= notify_nxt;
      tok_r    <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    period_r <= period_nxt;
    reload_r <= reload_nxt;
  end

endmodule

/* rtl/stt_checker.sv */
`timescale 1ns / 1ps

module stt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [2:0] in_cmd,
  input logic       out_valid,
  input logic [1:0] out_kind,
  input logic       out_last
);
  import stt_pkg::*;

  // A fire beat is never the closing beat of its scan.
  a_fire_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_FIRE) |-> (!out_last && busy))
    else $error("fire beat marked last or outside a scan");

  // The scan-done beat closes the scan and releases busy.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_DONE) |-> (out_last && !busy))
    else $error("scan-done beat malformed");

  // A taken scan holds the block busy.
  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_SCAN) |=> busy)
    else $error("scan taken without busy");

  // A status beat comes in the cycle after a taken command.
  a_status_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_STATUS) |-> ($past(start && !busy) && out_last))
    else $error("status beat without a command");

endmodule

bind soft_timer_table stt_checker u_stt_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_cmd   (in_cmd),
  .out_valid(out_valid),
  .out_kind (out_kind),
  .out_last (out_last)
);

/* tb/sv/soft_timer_table_tb.sv */
`timescale 1ns / 1ps

// Testbench for the software timer table. Commands go in one at a time through the
// start/busy handshake. The bench keeps its own copy of the slot table: flags, periods
// and reload ticks. For every accepted command it works out the result beats the block
// must produce. Those beats wait in a queue and are checked in order against the
// out_valid strobe. The receiver side cannot stall, so only the sender inserts idle
// cycles.

module soft_timer_table_tb;
  import stt_pkg::*;

  localparam int SLOTS        = 16;
  localparam int TICKS        = 32;
  localparam int RESET_CYCLES = 9;
  localparam int RAND_CMDS    = 90;
  localparam int CALM_TAIL    = 20;
  localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
  localparam int CYCLE_LIMIT  = 200000;

  // Command codes the block must ignore.
  localparam logic [2:0] CMD_BAD6 = 3'd6;
  localparam logic [2:0] CMD_BAD7 = 3'd7;

  // A directed row either carries its expected beat written out, or it leaves the
  // expectation to the predictor.
  localparam logic BY_HAND  = 1'b1;
  localparam logic BY_MODEL = 1'b0;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  slot;
    logic [31:0] period;
    logic        single_run;
    logic        start_now;
    logic        notify_enable;
    logic [31:0] now;
  } cmd_item_t;

  typedef struct packed {
    kind_t      kind;
    logic       status;
    logic [3:0] slot_id;
    logic       freed;
    logic       last;
  } beat_t;

  typedef struct packed {
    cmd_item_t item;
    logic      by_hand;
    beat_t     beat;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_cmd;
  logic [3:0]  in_slot;
  logic [31:0] in_period;
  logic        in_single_run;
  logic        in_start_now;
  logic        in_notify_enable;
  logic [31:0] in_now;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic        out_status;
  logic [3:0]  out_slot_id;
  logic        out_freed;
  logic        out_last;

  // The bench's own picture of the slot table.
  bit          tbl_used   [SLOTS];
  bit          tbl_active [SLOTS];
  bit          tbl_single [SLOTS];
  bit          tbl_killed [SLOTS];
  bit          tbl_notify [SLOTS];
  logic [31:0] tbl_period [SLOTS];
  logic [31:0] tbl_reload [SLOTS];

  beat_t     step_beats[$];    // beats caused by the command just accepted
  beat_t     awaited_beats[$]; // beats the block still owes, oldest first
  plan_row_t directed_plan[$];
  beat_t     seen_want;

  logic [31:0] sys_tick;
  int          fail_count;
  int          cycles;
  int          beats_checked;
  int          fires_seen;
  int          frees_seen;
  int          not_found_seen;

  always #1 clk = ~clk;

  soft_timer_table #(
    .NUM_SLOTS(SLOTS),
    .TICK_BITS(TICKS)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_slot          (in_slot),
    .in_period        (in_period),
    .in_single_run    (in_single_run),
    .in_start_now     (in_start_now),
    .in_notify_enable (in_notify_enable),
    .in_now           (in_now),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_status       (out_status),
    .out_slot_id      (out_slot_id),
    .out_freed        (out_freed),
    .out_last         (out_last)
  );

  function automatic beat_t mk_beat(kind_t k, logic st, logic [3:0] id, logic fr, logic lst);
    beat_t b;
    b.kind    = k;
    b.status  = st;
    b.slot_id = id;
    b.freed   = fr;
    b.last    = lst;
    return b;
  endfunction

  // Applies one command to the bench's table and leaves the beats it causes in
  // step_beats. Every slot index is in range here, since the slot field is as wide
  // as the table.
  function automatic void predict_table_beats(cmd_item_t it);
    int          i;
    logic [31:0] elapsed;
    logic [3:0]  freed_id;
    logic        freed_any;
    logic        st;
    step_beats.delete();
    case (it.cmd)
      CMD_REG: begin
        tbl_used[it.slot]   = 1'b1;
        tbl_active[it.slot] = it.start_now;
        tbl_single[it.slot] = it.single_run;
        tbl_killed[it.slot] = 1'b0;
        tbl_notify[it.slot] = it.notify_enable;
        tbl_period[it.slot] = it.period;
        tbl_reload[it.slot] = it.now;
        step_beats.push_back(mk_beat(KIND_STATUS, ST_OK, it.slot, 1'b0, 1'b1));
      end
      CMD_START, CMD_STOP, CMD_DEL: begin
        st = ST_NOT_FOUND;
        if (tbl_used[it.slot]) begin
          tbl_active[it.slot] = (it.cmd == CMD_START);
          if (it.cmd == CMD_DEL) tbl_killed[it.slot] = 1'b1;
          st = ST_OK;
        end
        step_beats.push_back(mk_beat(KIND_STATUS, st, it.slot, 1'b0, 1'b1));
      end
      CMD_DEL_ALL: begin
        for (i = 0; i < SLOTS; i++) begin
          if (tbl_used[i]) begin
            tbl_active[i] = 1'b0;
            tbl_killed[i] = 1'b1;
          end
        end
        step_beats.push_back(mk_beat(KIND_STATUS, ST_OK, 4'd0, 1'b0, 1'b1));
      end
      CMD_SCAN: begin
        freed_id  = 4'd0;
        freed_any = 1'b0;
        // The scan stops right after the first slot it frees.
        for (i = 0; i < SLOTS && !freed_any; i++) begin
          if (tbl_used[i]) begin
            elapsed = it.now - tbl_reload[i];
            if (tbl_active[i] && elapsed >= tbl_period[i]) begin
              tbl_reload[i] = it.now;
              if (tbl_single[i]) tbl_active[i] = 1'b0;
              if (tbl_notify[i] && !tbl_killed[i])
                step_beats.push_back(mk_beat(KIND_FIRE, ST_OK, 4'(i), 1'b0, 1'b0));
            end
            if (!tbl_active[i] && (tbl_single[i] || tbl_killed[i])) begin
              tbl_used[i]   = 1'b0;
              tbl_single[i] = 1'b0;
              tbl_killed[i] = 1'b0;
              tbl_notify[i] = 1'b0;
              freed_id      = 4'(i);
              freed_any     = 1'b1;
            end
          end
        end
        step_beats.push_back(mk_beat(KIND_DONE, ST_OK, freed_id, freed_any, 1'b1));
      end
      default: begin
        // Unknown codes leave the table alone and produce no beat.
      end
    endcase
  endfunction

  function automatic void plan(logic [2:0] c, logic [3:0] s, logic [31:0] p, logic sr,
                               logic sn, logic ne, logic [31:0] t, logic how, kind_t k,
                               logic st, logic [3:0] id);
    plan_row_t r;
    r.item.cmd           = c;
    r.item.slot          = s;
    r.item.period        = p;
    r.item.single_run    = sr;
    r.item.start_now     = sn;
    r.item.notify_enable = ne;
    r.item.now           = t;
    r.by_hand            = how;
    r.beat               = mk_beat(k, st, id, 1'b0, 1'b1);
    directed_plan.push_back(r);
  endfunction

  // Random commands mostly work on a handful of slots and let the tick creep forward,
  // so that timers really expire, fire and get freed. Now and then the tick jumps
  // anywhere, which exercises the wrapping elapsed count.
  function automatic cmd_item_t rand_item();
    cmd_item_t it;
    int        pick;
    pick = $urandom_range(0, 99);
    if (pick < 25)      it.cmd = CMD_REG;
    else if (pick < 35) it.cmd = CMD_START;
    else if (pick < 45) it.cmd = CMD_STOP;
    else if (pick < 52) it.cmd = CMD_DEL;
    else if (pick < 54) it.cmd = CMD_DEL_ALL;
    else if (pick < 95) it.cmd = CMD_SCAN;
    else                it.cmd = pick[0] ? CMD_BAD7 : CMD_BAD6;
    it.slot = $urandom_range(0, 1) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 5));
    case ($urandom_range(0, 9))
      7, 8:    it.period = $urandom_range(0, 300);
      9:       it.period = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
      default: it.period = $urandom_range(0, 20);
    endcase
    it.single_run    = 1'($urandom_range(0, 1));
    it.start_now     = ($urandom_range(0, 3) != 0);
    it.notify_enable = ($urandom_range(0, 3) != 0);
    if (it.cmd == CMD_SCAN) begin
      if ($urandom_range(0, 14) == 0) sys_tick = $urandom;
      else                            sys_tick = sys_tick + $urandom_range(0, 12);
    end
    it.now = ($urandom_range(0, 9) == 0) ? $urandom : sys_tick;
    return it;
  endfunction

  // Idle bursts come in groups of commands; every third group of sixteen runs with
  // no gaps, and the tail of the run has none at all.
  function automatic int pick_gap(int idx, int total);
    if (idx >= total - CALM_TAIL || (idx / 16) % 3 == 2) return 0;
    if ($urandom_range(0, 2) != 0) return 0;
    return $urandom_range(1, 10);
  endfunction

  // Holds the command on the input ports until the block takes it, then books the
  // beats it owes. The caller either lowers start for a gap or drives the next
  // command in the same step, so start sees one assignment per edge.
  task automatic drive_item(cmd_item_t it, logic how, beat_t hand_beat);
    start            <= 1'b1;
    in_cmd           <= it.cmd;
    in_slot          <= it.slot;
    in_period        <= it.period;
    in_single_run    <= it.single_run;
    in_start_now     <= it.start_now;
    in_notify_enable <= it.notify_enable;
    in_now           <= it.now;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predict_table_beats(it);
    if (how == BY_HAND) awaited_beats.push_back(hand_beat);
    else foreach (step_beats[j]) awaited_beats.push_back(step_beats[j]);
  endtask

  task automatic idle_gap(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Result side: a beat is taken at the edge that ends its strobe cycle, so the
  // outputs are sampled here before the block updates them.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (awaited_beats.size() == 0) begin
        $error("unexpected beat: kind %0d slot_id %0d", out_kind, out_slot_id);
        fail_count++;
      end else begin
        seen_want = awaited_beats.pop_front();
        beats_checked++;
        if (out_kind !== seen_want.kind) begin
          $error("kind: expected %0d, got %0d", seen_want.kind, out_kind);
          fail_count++;
        end
        if (out_status !== seen_want.status) begin
          $error("status: expected %0d, got %0d", seen_want.status, out_status);
          fail_count++;
        end
        if (out_slot_id !== seen_want.slot_id) begin
          $error("slot_id: expected %0d, got %0d", seen_want.slot_id, out_slot_id);
          fail_count++;
        end
        if (out_freed !== seen_want.freed) begin
          $error("freed: expected %0d, got %0d", seen_want.freed, out_freed);
          fail_count++;
        end
        if (out_last !== seen_want.last) begin
          $error("last: expected %0d, got %0d", seen_want.last, out_last);
          fail_count++;
        end
        if (seen_want.kind == KIND_FIRE) fires_seen++;
        if (seen_want.freed) frees_seen++;
        if (seen_want.status == ST_NOT_FOUND) not_found_seen++;
      end
    end
  end

  // Watchdog: a hung handshake or a missing beat ends the run here.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    cmd_item_t it;
    int        gap;
    int        n_cmds;
    int        idx;

    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_cmd           <= CMD_REG;
    in_slot          <= 4'd0;
    in_period        <= 32'd0;
    in_single_run    <= 1'b0;
    in_start_now     <= 1'b0;
    in_notify_enable <= 1'b0;
    in_now           <= 32'd0;
    fail_count       = 0;
    beats_checked    = 0;
    fires_seen       = 0;
    frees_seen       = 0;
    not_found_seen   = 0;
    sys_tick         = 32'd0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_used[i]   = 1'b0;
      tbl_active[i] = 1'b0;
      tbl_single[i] = 1'b0;
      tbl_killed[i] = 1'b0;
      tbl_notify[i] = 1'b0;
      tbl_period[i] = 32'd0;
      tbl_reload[i] = 32'd0;
    end

    //   cmd          slot  period        sr    sn    ne    now
    // An empty table after reset: the scan frees nothing, slot commands miss.
    plan(CMD_SCAN,    4'd0, 32'd0,        1'b0, 1'b0, 1'b0, 32'd0,
         BY_HAND, KIND_DONE, ST_OK, 4'd0);
    plan(CMD_START,   4'd3, 32'd0,        1'b0, 1'b0, 1'b0, 32'd0,
         BY_HAND, KIND_STATUS, ST_NOT_FOUND, 4'd3);
    plan(CMD_STOP,    4'd15, 32'd0,       1'b0, 1'b0, 1'b0, 32'd0,
         BY_HAND, KIND_STATUS, ST_NOT_FOUND, 4'd15);
    plan(CMD_DEL,     4'd0, 32'd0,        1'b0, 1'b0, 1'b0, 32'd0,
         BY_HAND, KIND_STATUS, ST_NOT_FOUND, 4'd0);
    plan(CMD_DEL_ALL, 4'd9, 32'd0,        1'b0, 1'b0, 1'b0, 32'd0,
         BY_HAND, KIND_STATUS, ST_OK, 4'd0);
    // Extreme periods and ticks: a zero period fires on every scan, the largest
    // one only after a full wrap.
    plan(CMD_REG,     4'd0, 32'd0,        1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF,
         BY_HAND, KIND_STATUS, ST_OK, 4'd0);
    plan(CMD_REG,     4'd15, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 32'd0,
         BY_HAND, KIND_STATUS, ST_OK, 4'd15);
    plan(CMD_REG,     4'd7, 32'd10,       1'b0, 1'b0, 1'b0, 32'd5,
         BY_HAND, KIND_STATUS, ST_OK, 4'd7);
    plan(CMD_SCAN,    4'd0, 32'd0,        1'b0, 1'b0, 1'b0, 32'd0,
         BY_MODEL, KIND_STATUS, ST_OK, 4'd0);
    plan(CMD_START,   4'd7, 32'd0,        1'b0, 1'b0, 1'b0, 32'd0,
         BY_HAND, KIND_STATUS, ST_OK, 4'd7);
    // The tick has gone below slot 7's reload tick, so its elapsed count wraps;
    // it expires silently because it has notify off.
    plan(CMD_SCAN,    4'd0, 32'd0,        1'b0, 1'b0, 1'b0, 32'd3,
         BY_MODEL, KIND_STATUS, ST_OK, 4'd0);
    // Registering a used slot overwrites it; the one-shot then fires and is freed.
    plan(CMD_REG,     4'd15, 32'd2,       1'b1, 1'b1, 1'b1, 32'hFFFF_FFFE,
         BY_HAND, KIND_STATUS, ST_OK, 4'd15);
    plan(CMD_SCAN,    4'd0, 32'd0,        1'b0, 1'b0, 1'b0, 32'd0,
         BY_MODEL, KIND_STATUS, ST_OK, 4'd0);
    // Unknown codes must produce nothing.
    plan(CMD_BAD6,    4'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF,
         BY_MODEL, KIND_STATUS, ST_OK, 4'd0);
    plan(CMD_BAD7,    4'd15, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF,
         BY_MODEL, KIND_STATUS, ST_OK, 4'd0);
    plan(CMD_STOP,    4'd0, 32'd0,        1'b0, 1'b0, 1'b0, 32'd0,
         BY_HAND, KIND_STATUS, ST_OK, 4'd0);
    // An idle one-shot is freed by the next scan, which then stops early.
    plan(CMD_REG,     4'd4, 32'd5,        1'b1, 1'b0, 1'b1, 32'd100,
         BY_HAND, KIND_STATUS, ST_OK, 4'd4);
    plan(CMD_SCAN,    4'd0, 32'd0,        1'b0, 1'b0, 1'b0, 32'd100,
         BY_MODEL, KIND_STATUS, ST_OK, 4'd0);
    // A deleted slot can be restarted; it then expires without a fire event.
    plan(CMD_DEL,     4'd7, 32'd0,        1'b0, 1'b0, 1'b0, 32'd0,
         BY_HAND, KIND_STATUS, ST_OK, 4'd7);
    plan(CMD_START,   4'd7, 32'd0,        1'b0, 1'b0, 1'b0, 32'd0,
         BY_HAND, KIND_STATUS, ST_OK, 4'd7);
    plan(CMD_SCAN,    4'd0, 32'd0,        1'b0, 1'b0, 1'b0, 32'd200,
         BY_MODEL, KIND_STATUS, ST_OK, 4'd0);
    plan(CMD_STOP,    4'd7, 32'd0,        1'b0, 1'b0, 1'b0, 32'd0,
         BY_HAND, KIND_STATUS, ST_OK, 4'd7);
    // A freed slot answers not-found until it is registered again.
    plan(CMD_START,   4'd4, 32'd0,        1'b0, 1'b0, 1'b0, 32'd0,
         BY_HAND, KIND_STATUS, ST_NOT_FOUND, 4'd4);
    plan(CMD_DEL_ALL, 4'd0, 32'd0,        1'b0, 1'b0, 1'b0, 32'd0,
         BY_HAND, KIND_STATUS, ST_OK, 4'd0);
    // Each scan frees one deleted slot, in ascending order, until the table is empty.
    plan(CMD_SCAN,    4'd0, 32'd0,        1'b0, 1'b0, 1'b0, 32'd300,
         BY_MODEL, KIND_STATUS, ST_OK, 4'd0);
    plan(CMD_SCAN,    4'd0, 32'd0,        1'b0, 1'b0, 1'b0, 32'd301,
         BY_MODEL, KIND_STATUS, ST_OK, 4'd0);
    plan(CMD_SCAN,    4'd0, 32'd0,        1'b0, 1'b0, 1'b0, 32'd302,
         BY_HAND, KIND_DONE, ST_OK, 4'd0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      gap = pick_gap(i, directed_plan.size() + RAND_CMDS + CALM_TAIL);
      if (gap > 0) idle_gap(gap);
      drive_item(directed_plan[i].item, directed_plan[i].by_hand, directed_plan[i].beat);
    end

    // Random part. Ignored codes do not count toward the total.
    sys_tick = 32'd400;
    n_cmds   = 0;
    idx      = 0;
    while (n_cmds < RAND_CMDS) begin
      it  = rand_item();
      gap = pick_gap(n_cmds, RAND_CMDS);
      if (gap > 0) idle_gap(gap);
      drive_item(it, BY_MODEL, mk_beat(KIND_STATUS, ST_OK, 4'd0, 1'b0, 1'b0));
      if (it.cmd <= CMD_SCAN) n_cmds++;
      idx++;
    end

    start <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk);
    // Give a stray beat time to show up after the last expected one.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Drove %0d directed and %0d random commands, checked %0d result beats.",
             directed_plan.size(), idx, beats_checked);
    $display("Seen: %0d fire events, %0d slot frees, %0d not-found answers.",
             fires_seen, frees_seen, not_found_seen);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
